// ===== rtl/ran_pkg.sv =====
// ----------------------------------------------------------------------------
// ran_pkg
// Shared types and constants for the rational adder with gcd reduction.
// ----------------------------------------------------------------------------
package ran_pkg;

  localparam int WIDTH     = 16;
  localparam int MAG_W     = 2 * WIDTH;
  localparam int SUM_NUM_W = 33;
  localparam int SUM_DEN_W = 31;
  localparam int SHIFT_W   = $clog2(MAG_W + 1);
  localparam int CNT_W     = $clog2(MAG_W + 1);

  typedef struct packed {
    logic signed [WIDTH-1:0] a_num;
    logic signed [WIDTH-1:0] a_den;
    logic signed [WIDTH-1:0] b_num;
    logic signed [WIDTH-1:0] b_den;
  } ran_req_t;

  typedef struct packed {
    logic signed [SUM_NUM_W-1:0] sum_num;
    logic [SUM_DEN_W-1:0]        sum_den;
    logic                        den_zero_error;
  } ran_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P1,
    ST_MUL_P2,
    ST_MUL_DEN,
    ST_ADD,
    ST_CHECK,
    ST_GCD,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } ran_state_e;

  typedef enum logic [1:0] {
    MUL_P1,
    MUL_P2,
    MUL_DEN
  } ran_mul_sel_e;

  typedef struct packed {
    logic         load;
    logic         mul_en;
    ran_mul_sel_e mul_sel;
    logic         add_en;
    logic         gcd_init;
    logic         gcd_step;
    logic         div_init;
    logic         div_step;
    logic         out_en;
  } ran_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic gcd_done;
    logic div_done;
  } ran_sts_t;

endpackage

// ===== rtl/rational_add_normalize.sv =====
// ----------------------------------------------------------------------------
// rational_add_normalize
// Adds two signed fractions and reduces the sum by its gcd.
// ----------------------------------------------------------------------------
//  channel   signals                 handshake
//  request   start, busy, req_i      taken when start is high and busy low
//  result    done_o, rsp_o           done_o high for one cycle, no backpressure
//
//  One request is in flight at a time; busy stays high until the result.
//  The sequence runs the multiplies, the add, the binary gcd and the divide
//  steps, one quotient bit per divide step; a zero denominator or a zero sum
//  skips straight to the result.
//  Reset clears the sequencer and the result strobe.
// ----------------------------------------------------------------------------
module rational_add_normalize (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ran_pkg::ran_req_t req_i,
  output logic              done_o,
  output ran_pkg::ran_rsp_t rsp_o
);
  import ran_pkg::*;

  ran_cmd_t cmd;
  ran_sts_t sts;

  ran_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ran_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

// ===== rtl/ran_ctrl.sv =====
// ----------------------------------------------------------------------------
// ran_ctrl
// Sequencer: steps the datapath through multiply, add, gcd and divide.
// ----------------------------------------------------------------------------
module ran_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ran_pkg::ran_sts_t sts_i,
  output ran_pkg::ran_cmd_t cmd_o
);
  import ran_pkg::*;

  ran_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_MUL_P1;
      end
      ST_MUL_P1: begin
        state_d = sts_i.den_zero ? ST_OUT : ST_MUL_P2;
      end
      ST_MUL_P2:   state_d = ST_MUL_DEN;
      ST_MUL_DEN:  state_d = ST_ADD;
      ST_ADD:      state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = sts_i.num_zero ? ST_OUT : ST_GCD;
      end
      ST_GCD: begin
        if (sts_i.gcd_done) state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_OUT;
      end
      ST_OUT:      state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_sel = MUL_P1;
    case (state_q)
      ST_IDLE:     cmd_o.load = start;
      ST_MUL_P1: begin
        cmd_o.mul_en  = !sts_i.den_zero;
        cmd_o.mul_sel = MUL_P1;
      end
      ST_MUL_P2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_P2;
      end
      ST_MUL_DEN: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DEN;
      end
      ST_ADD:      cmd_o.add_en   = 1'b1;
      ST_CHECK:    cmd_o.gcd_init = !sts_i.num_zero;
      ST_GCD:      cmd_o.gcd_step = !sts_i.gcd_done;
      ST_DIV_INIT: cmd_o.div_init = 1'b1;
      ST_DIV:      cmd_o.div_step = !sts_i.div_done;
      ST_OUT:      cmd_o.out_en   = 1'b1;
      default:     cmd_o = '0;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/ran_dp.sv =====
// ----------------------------------------------------------------------------
// ran_dp
// Datapath: sign split, shared multiplier, sign-magnitude add, binary gcd
// and two restoring dividers that share the gcd as divisor.
// ----------------------------------------------------------------------------
module ran_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ran_pkg::ran_req_t req_i,
  input  ran_pkg::ran_cmd_t cmd_i,
  output ran_pkg::ran_sts_t sts_o,
  output logic              done_o,
  output ran_pkg::ran_rsp_t rsp_o
);
  import ran_pkg::*;

  // operand signs and magnitudes
  logic             an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
  logic [WIDTH-1:0] anm_q, adm_q, bnm_q, bdm_q;

  logic [MAG_W-1:0] p1_q, p2_q, den_q;
  logic [MAG_W-1:0] num_mag_q;
  logic             num_neg_q;

  logic [MAG_W-1:0]   x_q, y_q;
  logic [SHIFT_W-1:0] k_q;

  logic [MAG_W-1:0] g_q;
  logic [MAG_W-1:0] qa_q, qb_q, ra_q, rb_q;
  logic [CNT_W-1:0] cnt_q;

  logic     done_q;
  ran_rsp_t rsp_q, rsp_d;

  logic [WIDTH-1:0] op_a, op_b;
  logic [MAG_W-1:0] prod;
  logic             p1_neg, p2_neg, den_neg;
  logic [MAG_W-1:0] add_mag;
  logic             add_neg;
  logic [MAG_W:0]   trial_a, trial_b, diff_a, diff_b;
  logic             fit_a, fit_b;
  logic [SUM_NUM_W-1:0] q_ext;

  function automatic logic [WIDTH-1:0] mag_of(logic [WIDTH-1:0] v);
    return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      an_neg_q <= req_i.a_num[WIDTH-1];
      ad_neg_q <= req_i.a_den[WIDTH-1];
      bn_neg_q <= req_i.b_num[WIDTH-1];
      bd_neg_q <= req_i.b_den[WIDTH-1];
      anm_q    <= mag_of(req_i.a_num);
      adm_q    <= mag_of(req_i.a_den);
      bnm_q    <= mag_of(req_i.b_num);
      bdm_q    <= mag_of(req_i.b_den);
    end
  end

  // one multiplier, three products in turn
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_P1: begin
        op_a = anm_q;
        op_b = bdm_q;
      end
      MUL_P2: begin
        op_a = adm_q;
        op_b = bnm_q;
      end
      MUL_DEN: begin
        op_a = adm_q;
        op_b = bdm_q;
      end
      default: begin
        op_a = anm_q;
        op_b = bdm_q;
      end
    endcase
  end

  assign prod = MAG_W'(op_a) * MAG_W'(op_b);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_P1:  p1_q  <= prod;
        MUL_P2:  p2_q  <= prod;
        MUL_DEN: den_q <= prod;
        default: p1_q  <= prod;
      endcase
    end
  end

  assign p1_neg  = an_neg_q ^ bd_neg_q;
  assign p2_neg  = ad_neg_q ^ bn_neg_q;
  assign den_neg = ad_neg_q ^ bd_neg_q;

  always_comb begin
    if (p1_neg == p2_neg) begin
      add_mag = p1_q + p2_q;
      add_neg = p1_neg;
    end else if (p1_q >= p2_q) begin
      add_mag = p1_q - p2_q;
      add_neg = p1_neg;
    end else begin
      add_mag = p2_q - p1_q;
      add_neg = p2_neg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_en) begin
      num_mag_q <= add_mag;
      // move the denominator sign onto the numerator
      num_neg_q <= add_neg ^ den_neg;
    end
  end

  // binary gcd: only x can reach zero, the gcd is then y << k
  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      x_q <= num_mag_q;
      y_q <= den_q;
      k_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + SHIFT_W'(1);
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q >= y_q) begin
        x_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
  end

  assign trial_a = {ra_q, qa_q[MAG_W-1]};
  assign trial_b = {rb_q, qb_q[MAG_W-1]};
  assign diff_a  = trial_a - {1'b0, g_q};
  assign diff_b  = trial_b - {1'b0, g_q};
  assign fit_a   = (trial_a >= {1'b0, g_q});
  assign fit_b   = (trial_b >= {1'b0, g_q});

  // restoring division, one quotient bit per cycle for both parts
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      g_q   <= y_q << k_q;
      qa_q  <= num_mag_q;
      qb_q  <= den_q;
      ra_q  <= '0;
      rb_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      ra_q  <= fit_a ? diff_a[MAG_W-1:0] : trial_a[MAG_W-1:0];
      rb_q  <= fit_b ? diff_b[MAG_W-1:0] : trial_b[MAG_W-1:0];
      qa_q  <= {qa_q[MAG_W-2:0], fit_a};
      qb_q  <= {qb_q[MAG_W-2:0], fit_b};
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  assign sts_o.den_zero = (adm_q == '0) || (bdm_q == '0);
  assign sts_o.num_zero = (num_mag_q == '0);
  assign sts_o.gcd_done = (x_q == '0);
  assign sts_o.div_done = (cnt_q == CNT_W'(MAG_W));

  assign q_ext = SUM_NUM_W'(qa_q);

  always_comb begin
    rsp_d = '0;
    if (sts_o.den_zero) begin
      rsp_d.sum_den        = SUM_DEN_W'(1);
      rsp_d.den_zero_error = 1'b1;
    end else if (sts_o.num_zero) begin
      rsp_d.sum_den = SUM_DEN_W'(1);
    end else begin
      rsp_d.sum_num = num_neg_q ? (~q_ext + SUM_NUM_W'(1)) : q_ext;
      rsp_d.sum_den = SUM_DEN_W'(qb_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_en) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.out_en;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/ran_checker.sv =====
// ----------------------------------------------------------------------------
// ran_checker
// Port-level checks for the rational adder, bound to the top level.
// ----------------------------------------------------------------------------
module ran_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input ran_pkg::ran_rsp_t rsp_o
);
  import ran_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.sum_den != '0))
    else $error("zero denominator in result");

  a_err_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.den_zero_error) |->
      (rsp_o.sum_num == '0 && rsp_o.sum_den == SUM_DEN_W'(1)))
    else $error("error result is not 0/1");

endmodule

bind rational_add_normalize ran_checker u_ran_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
